/* design/ecc_pkg.sv */
// Shared types, widths, codes and helpers for the elevator car controller.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package ecc_pkg;

  localparam int KIND_W  = 2;
  localparam int FLOOR_W = 6;
  localparam int TIME_W  = 10;
  localparam int STATE_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [FLOOR_W-1:0] TOP_FLOOR   = FLOOR_W'(63);
  localparam logic [FLOOR_W-1:0] RESET_FLOOR = FLOOR_W'(1);

  localparam logic [TIME_W-1:0] RESET_OPEN_TIME   = TIME_W'(10);
  localparam logic [TIME_W-1:0] RESET_CLOSE_TIME  = TIME_W'(10);
  localparam logic [TIME_W-1:0] RESET_DWELL_TIME  = TIME_W'(30);
  localparam logic [TIME_W-1:0] RESET_TRAVEL_TIME = TIME_W'(20);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TIME   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_TIME  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL_TIME  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_TIME = 2'd3;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE  = 2'd0,
    KIND_CALL  = 2'd1,
    KIND_OPEN  = 2'd2,
    KIND_CLOSE = 2'd3
  } kind_t;

  typedef enum logic [STATE_W-1:0] {
    MODE_IDLE    = 3'd0,
    MODE_OPENING = 3'd1,
    MODE_STOPPED = 3'd2,
    MODE_CLOSING = 3'd3,
    MODE_UP      = 3'd4,
    MODE_DOWN    = 3'd5
  } mode_t;

  typedef struct packed {
    logic [TIME_W-1:0] open_time;
    logic [TIME_W-1:0] close_time;
    logic [TIME_W-1:0] dwell_time;
    logic [TIME_W-1:0] floor_travel_time;
  } cfg_t;

  typedef struct packed {
    logic               consumed;
    logic [KIND_W-1:0]  consumed_kind;
    logic [FLOOR_W-1:0] consumed_floor;
    logic [STATE_W-1:0] car_state;
    logic [FLOOR_W-1:0] car_floor;
    logic [FLOOR_W-1:0] target_floor;
  } step_res_t;

  // Saturating subtract: a - b, floored at zero
  function automatic logic [TIME_W-1:0] sat_sub(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] diff;
    diff = a - b;
    return (a > b) ? diff : '0;
  endfunction

endpackage

/* design/ecc_req_if.sv */
// Request channel: valid/ready handshake carrying the head request of the queue.
// Depends on ecc_pkg for field widths.
`timescale 1ns / 1ps

interface ecc_req_if;
  import ecc_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  request_kind;
  logic [FLOOR_W-1:0] request_floor;

  modport source (output valid, output request_kind, output request_floor, input ready);
  modport sink   (input valid, input request_kind, input request_floor, output ready);
endinterface

/* design/ecc_res_if.sv */
// Result channel: valid/ready handshake carrying one result item per tick.
// Depends on ecc_pkg for field widths.
`timescale 1ns / 1ps

interface ecc_res_if;
  import ecc_pkg::*;

  logic               valid;
  logic               ready;
  logic               consumed;
  logic [KIND_W-1:0]  consumed_kind;
  logic [FLOOR_W-1:0] consumed_floor;
  logic [STATE_W-1:0] car_state;
  logic [FLOOR_W-1:0] car_floor;
  logic [FLOOR_W-1:0] target_floor;

  modport source (output valid, output consumed, output consumed_kind,
                  output consumed_floor, output car_state, output car_floor,
                  output target_floor, input ready);
  modport sink   (input valid, input consumed, input consumed_kind,
                  input consumed_floor, input car_state, input car_floor,
                  input target_floor, output ready);
endinterface

/* design/elevator_car_controller.sv */
// Top level of the elevator car controller: input register, car state machine,
// result register. Depends on ecc_pkg, ecc_req_if, ecc_res_if, ecc_cfg_regs, ecc_core.
//
//   Channel  Dir  Handshake      Payload
//   req      in   valid/ready    request_kind[1:0], request_floor[5:0]
//   res      out  valid/ready    consumed, consumed_kind[1:0], consumed_floor[5:0],
//                                car_state[2:0], car_floor[5:0], target_floor[5:0]
//   cfg      in   cfg_we only    cfg_index[1:0], cfg_data[9:0]
//
// One item a cycle sustained while the result channel is ready; each item's result
// passes through the input register, then the state update into the result register,
// where it is presented until taken.
// The throughput is set by the state update in the car state machine.
// Synchronous reset puts the car idle at floor 1 with the timer at zero and
// restores the default timings; no clearing pass is needed.
// A stalled result holds in the output register while the input register keeps
// taking items until it too is full.
`timescale 1ns / 1ps

module elevator_car_controller (
  input  logic                          clk,
  input  logic                          rst,
  ecc_req_if.sink                       req,
  ecc_res_if.source                     res,
  input  logic                          cfg_we,
  input  logic [ecc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ecc_pkg::TIME_W-1:0]    cfg_data
);
  import ecc_pkg::*;

  // Input register
  logic               s1_valid;
  logic [KIND_W-1:0]  s1_kind;
  logic [FLOOR_W-1:0] s1_floor;

  // Result register
  logic      out_valid;
  step_res_t out_res;

  cfg_t      cfg;
  step_res_t step_res;
  logic      advance;

  // Advance the held item into the state machine when the result slot is free
  // or being drained this cycle.
  assign advance   = s1_valid && (!out_valid || res.ready);
  assign req.ready = !s1_valid || advance;

  ecc_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  ecc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step_en  (advance),
    .kind     (s1_kind),
    .floor_in (s1_floor),
    .cfg      (cfg),
    .res      (step_res)
  );

  // Input register: take a new item whenever the slot is empty or emptying
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_kind  <= req.request_kind;
      s1_floor <= req.request_floor;
    end
  end

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign res.valid          = out_valid;
  assign res.consumed       = out_res.consumed;
  assign res.consumed_kind  = out_res.consumed_kind;
  assign res.consumed_floor = out_res.consumed_floor;
  assign res.car_state      = out_res.car_state;
  assign res.car_floor      = out_res.car_floor;
  assign res.target_floor   = out_res.target_floor;

endmodule

/* design/ecc_cfg_regs.sv */
// Timing configuration registers written through a plain write port.
// Depends on ecc_pkg for cfg_t, register indexes and reset values.
`timescale 1ns / 1ps

module ecc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             we,
  input  logic [ecc_pkg::CFG_IDX_W-1:0]    index,
  input  logic [ecc_pkg::TIME_W-1:0]       data,
  output ecc_pkg::cfg_t                    cfg
);
  import ecc_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.open_time         <= RESET_OPEN_TIME;
      regs.close_time        <= RESET_CLOSE_TIME;
      regs.dwell_time        <= RESET_DWELL_TIME;
      regs.floor_travel_time <= RESET_TRAVEL_TIME;
    end else if (we) begin
      case (index)
        CFG_OPEN_TIME:   regs.open_time         <= data;
        CFG_CLOSE_TIME:  regs.close_time        <= data;
        CFG_DWELL_TIME:  regs.dwell_time        <= data;
        CFG_TRAVEL_TIME: regs.floor_travel_time <= data;
        default:         regs <= regs;
      endcase
    end
  end

  assign cfg = regs;

endmodule

/* design/ecc_core.sv */
// Car state machine: mode, floors and countdown, updated once per accepted tick.
// Depends on ecc_pkg for mode_t, kind_t, cfg_t, step_res_t and sat_sub.
`timescale 1ns / 1ps

module ecc_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step_en,
  input  logic [ecc_pkg::KIND_W-1:0]   kind,
  input  logic [ecc_pkg::FLOOR_W-1:0]  floor_in,
  input  ecc_pkg::cfg_t                cfg,
  output ecc_pkg::step_res_t           res
);
  import ecc_pkg::*;

  mode_t              mode, mode_next;
  logic [FLOOR_W-1:0] floor_now, floor_now_next;
  logic [FLOOR_W-1:0] floor_goal, floor_goal_next;
  logic [TIME_W-1:0]  countdown, countdown_next;
  logic               used;

  logic [FLOOR_W-1:0] fl_sat;
  logic [FLOOR_W-1:0] floor_inc, floor_dec;
  mode_t              call_mode;
  logic [FLOOR_W-1:0] call_goal;
  logic [TIME_W-1:0]  call_cd;
  logic [TIME_W-1:0]  cd_dec;

  // Start of a floor call from rest with the door shut
  always_comb begin
    fl_sat    = (floor_in > TOP_FLOOR) ? TOP_FLOOR : floor_in;
    floor_inc = floor_now + FLOOR_W'(1);
    floor_dec = floor_now - FLOOR_W'(1);
    cd_dec    = countdown - TIME_W'(1);
    if (fl_sat > floor_now) begin
      call_mode = MODE_UP;
      call_goal = fl_sat;
      call_cd   = cfg.floor_travel_time;
    end else if (fl_sat < floor_now) begin
      call_mode = MODE_DOWN;
      call_goal = fl_sat;
      call_cd   = cfg.floor_travel_time;
    end else begin
      call_mode = MODE_OPENING;
      call_goal = floor_goal;
      call_cd   = cfg.open_time;
    end
  end

  // Next state
  always_comb begin
    mode_next       = mode;
    floor_now_next  = floor_now;
    floor_goal_next = floor_goal;
    countdown_next  = countdown;
    used            = 1'b0;
    case (mode)
      MODE_IDLE: begin
        if (kind != KIND_NONE) begin
          used = 1'b1;
          if (kind == KIND_OPEN) begin
            mode_next      = MODE_OPENING;
            countdown_next = cfg.open_time;
          end else if (kind == KIND_CALL) begin
            mode_next       = call_mode;
            floor_goal_next = call_goal;
            countdown_next  = call_cd;
          end
        end
      end
      MODE_OPENING: begin
        if (kind == KIND_CLOSE) begin
          mode_next      = MODE_CLOSING;
          countdown_next = sat_sub(cfg.open_time, countdown);
          used           = 1'b1;
        end else if (countdown == '0) begin
          mode_next      = MODE_STOPPED;
          countdown_next = cfg.dwell_time;
        end else begin
          countdown_next = cd_dec;
        end
      end
      MODE_STOPPED: begin
        if (kind == KIND_OPEN) begin
          countdown_next = cfg.dwell_time;
          used           = 1'b1;
        end else if (kind == KIND_CLOSE || countdown == '0) begin
          mode_next      = MODE_CLOSING;
          countdown_next = cfg.close_time;
          used           = (kind == KIND_CLOSE);
        end else begin
          countdown_next = cd_dec;
        end
      end
      MODE_CLOSING: begin
        if (kind == KIND_OPEN) begin
          mode_next      = MODE_OPENING;
          countdown_next = sat_sub(cfg.close_time, countdown);
          used           = 1'b1;
        end else if (kind == KIND_CLOSE) begin
          used = 1'b1;
        end else if (countdown == '0) begin
          if (kind == KIND_CALL) begin
            mode_next       = call_mode;
            floor_goal_next = call_goal;
            countdown_next  = call_cd;
            used            = 1'b1;
          end else begin
            mode_next = MODE_IDLE;
          end
        end else begin
          countdown_next = cd_dec;
        end
      end
      MODE_UP: begin
        if (countdown != '0) begin
          countdown_next = cd_dec;
        end else if (floor_now < floor_goal) begin
          floor_now_next = floor_inc;
          if (floor_inc != floor_goal) countdown_next = cfg.floor_travel_time;
        end else begin
          mode_next      = MODE_OPENING;
          countdown_next = cfg.open_time;
        end
      end
      MODE_DOWN: begin
        if (countdown != '0) begin
          countdown_next = cd_dec;
        end else if (floor_now > floor_goal) begin
          floor_now_next = floor_dec;
          if (floor_dec != floor_goal) countdown_next = cfg.floor_travel_time;
        end else begin
          mode_next      = MODE_OPENING;
          countdown_next = cfg.open_time;
        end
      end
      default: mode_next = MODE_IDLE;
    endcase
  end

  // Result fields reflect the state after this tick
  always_comb begin
    res.consumed       = used;
    res.consumed_kind  = used ? kind : '0;
    res.consumed_floor = used ? fl_sat : '0;
    res.car_state      = mode_next;
    res.car_floor      = floor_now_next;
    res.target_floor   = floor_goal_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      floor_now  <= RESET_FLOOR;
      floor_goal <= RESET_FLOOR;
      countdown  <= '0;
    end else if (step_en) begin
      mode       <= mode_next;
      floor_now  <= floor_now_next;
      floor_goal <= floor_goal_next;
      countdown  <= countdown_next;
    end
  end

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !step_en |=> $stable(mode) && $stable(countdown) && $stable(floor_now))
    else $error("car state moved without an accepted tick");

  a_up_one_floor: assert property (@(posedge clk) disable iff (rst)
    step_en && mode == MODE_UP |=>
      floor_now == $past(floor_now) || floor_now == $past(floor_now) + FLOOR_W'(1))
    else $error("car moved more than one floor upwards in a tick");

  a_goal_from_rest: assert property (@(posedge clk) disable iff (rst)
    step_en && floor_goal_next != floor_goal |->
      mode == MODE_IDLE || mode == MODE_CLOSING)
    else $error("goal floor changed while the car was not at rest");

  a_consumed_kind: assert property (@(posedge clk) disable iff (rst)
    step_en && res.consumed |-> res.consumed_kind != KIND_NONE)
    else $error("empty request reported as consumed");

endmodule
